// ----- rtl/core/cxy_pkg.sv -----
// Shared constants and datapath step functions for the xy-to-RGB converter.
package cxy_pkg;

  localparam logic [15:0] Y_MIN = 16'd7;

  // Matrix coefficients scaled by 10000, one array per input term, indexed by output channel.
  localparam logic signed [39:0] CX [3] = '{40'sd32406, -40'sd9689, 40'sd557};
  localparam logic signed [39:0] CY [3] = '{-40'sd15372, 40'sd18758, -40'sd2040};
  localparam logic signed [39:0] CZ [3] = '{-40'sd4986, 40'sd415, 40'sd10570};

  localparam int DIV_STEPS = 33;
  localparam int SQRT_STEPS = 17;
  // Edges from the accepting edge to the first edge that samples the result.
  localparam int LATENCY = 55;

  localparam logic [1:0] REG_LEVEL = 2'd0;
  localparam logic [1:0] REG_ON = 2'd1;

  typedef struct packed {
    logic [31:0] rem;
    logic [32:0] quo;
  } div_t;

  typedef struct packed {
    logic [32:0] val;
    logic [33:0] res;
  } sqrt_t;

  // One bit of restoring division; the first step does not double.
  function automatic div_t div_step(input logic [31:0] rem, input logic [31:0] m,
                                    input logic [32:0] quo, input logic first);
    logic [32:0] sh;
    div_t o;
    sh = first ? {1'b0, rem} : {rem, 1'b0};
    if (sh >= {1'b0, m}) begin
      o.rem = 32'(sh - {1'b0, m});
      o.quo = {quo[31:0], 1'b1};
    end else begin
      o.rem = sh[31:0];
      o.quo = {quo[31:0], 1'b0};
    end
    return o;
  endfunction

  function automatic sqrt_t sqrt_step(input logic [32:0] val, input logic [33:0] res,
                                      input logic [33:0] bitv);
    logic [33:0] sum;
    sqrt_t o;
    sum = res + bitv;
    if ({1'b0, val} >= sum) begin
      o.val = 33'({1'b0, val} - sum);
      o.res = (res >> 1) + bitv;
    end else begin
      o.val = val;
      o.res = res >> 1;
    end
    return o;
  endfunction

endpackage

// ----- rtl/core/cie_xy_to_rgb_with_dimming.sv -----
// Pipelined CIE xy chromaticity to dimmed 8-bit RGB converter.
//
//   channel   signals                                  direction
//   input     start, busy, chroma_x, chroma_y          in (busy out)
//   result    result_valid, red_out, green_out, blue_out  out
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data   in (cfg_ready out)
//
// One word enters per cycle; busy is never raised.
// Each result passes the matrix stages, then the 33-stage divider and the
// 17-stage square root, and then the scaling and dimming registers.
// Reset clears all valid bits and loads brightness 128 with the light off.
// The receiver cannot stall, so the pipeline never holds.
module cie_xy_to_rgb_with_dimming (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] chroma_x,
  input  logic [15:0] chroma_y,
  output logic        result_valid,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import cxy_pkg::*;

  logic [7:0] level;
  logic       light_on;

  logic        s0_v;
  logic [15:0] s0_x, s0_y;
  logic        s1_v;
  logic [15:0] s1_y;
  logic signed [39:0] s1_n [3];
  logic        s2_v, s2_nz;
  logic [31:0] s2_n [3];
  logic [31:0] s2_m;

  logic        d_v   [DIV_STEPS];
  logic        d_nz  [DIV_STEPS];
  logic [31:0] d_m   [DIV_STEPS];
  logic [31:0] d_rem [DIV_STEPS][3];
  logic [32:0] d_quo [DIV_STEPS][3];

  logic        q_v   [SQRT_STEPS];
  logic        q_nz  [SQRT_STEPS];
  logic [32:0] q_val [SQRT_STEPS][3];
  logic [33:0] q_res [SQRT_STEPS][3];

  logic       b_v;
  logic [7:0] b_c [3];

  logic signed [39:0] nx, ny, nu;
  logic [31:0] cl [3];
  logic [31:0] mx;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= 8'd128;
      light_on <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEVEL: level <= cfg_data;
        REG_ON:    light_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    nx = $signed(40'(s0_x));
    ny = $signed(40'(s0_y));
    nu = 40'sd65536 - nx - ny;
  end

  // Clamp negative channels and find the brightest one.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cl[k] = s1_n[k][39] ? 32'd0 : s1_n[k][31:0];
    end
    mx = cl[0];
    if (cl[1] > mx) mx = cl[1];
    if (cl[2] > mx) mx = cl[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      b_v <= 1'b0;
      result_valid <= 1'b0;
      for (int i = 0; i < DIV_STEPS; i++) d_v[i] <= 1'b0;
      for (int i = 0; i < SQRT_STEPS; i++) q_v[i] <= 1'b0;
    end else begin
      s0_v <= start && !busy;
      s1_v <= s0_v;
      s2_v <= s1_v;
      d_v[0] <= s2_v;
      for (int i = 1; i < DIV_STEPS; i++) d_v[i] <= d_v[i-1];
      q_v[0] <= d_v[DIV_STEPS-1];
      for (int i = 1; i < SQRT_STEPS; i++) q_v[i] <= q_v[i-1];
      b_v <= q_v[SQRT_STEPS-1];
      result_valid <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    div_t dr;
    sqrt_t sr;
    logic [24:0] sc;
    logic [15:0] p;
    logic [16:0] ps;
    s0_x <= chroma_x;
    s0_y <= (chroma_y < Y_MIN) ? Y_MIN : chroma_y;

    s1_y <= s0_y;
    for (int k = 0; k < 3; k++) begin
      s1_n[k] <= CX[k] * nx + CY[k] * ny + CZ[k] * nu;
    end

    for (int k = 0; k < 3; k++) s2_n[k] <= cl[k];
    s2_m <= mx;
    s2_nz <= mx > {16'd0, s1_y};

    // Long division: each stage settles one quotient bit of n * 2^32 / m.
    d_m[0] <= s2_m;
    d_nz[0] <= s2_nz;
    for (int k = 0; k < 3; k++) begin
      dr = div_step(s2_n[k], s2_m, 33'd0, 1'b1);
      d_rem[0][k] <= dr.rem;
      d_quo[0][k] <= dr.quo;
    end
    for (int i = 1; i < DIV_STEPS; i++) begin
      d_m[i] <= d_m[i-1];
      d_nz[i] <= d_nz[i-1];
      for (int k = 0; k < 3; k++) begin
        dr = div_step(d_rem[i-1][k], d_m[i-1], d_quo[i-1][k], 1'b0);
        d_rem[i][k] <= dr.rem;
        d_quo[i][k] <= dr.quo;
      end
    end

    // Digit-by-digit square root, one result bit per stage.
    q_nz[0] <= d_nz[DIV_STEPS-1];
    for (int k = 0; k < 3; k++) begin
      sr = sqrt_step(d_quo[DIV_STEPS-1][k], 34'd0, 34'd1 << 32);
      q_val[0][k] <= sr.val;
      q_res[0][k] <= sr.res;
    end
    for (int i = 1; i < SQRT_STEPS; i++) begin
      q_nz[i] <= q_nz[i-1];
      for (int k = 0; k < 3; k++) begin
        sr = sqrt_step(q_val[i-1][k], q_res[i-1][k], 34'd1 << (32 - 2 * i));
        q_val[i][k] <= sr.val;
        q_res[i][k] <= sr.res;
      end
    end

    for (int k = 0; k < 3; k++) begin
      sc = 25'(q_res[SQRT_STEPS-1][k][16:0]) * 25'd255;
      b_c[k] <= q_nz[SQRT_STEPS-1] ? sc[23:16] : 8'd0;
    end

    // Floor division by 255 of a 16-bit product: (p + p/256 + 1) / 256.
    for (int k = 0; k < 3; k++) begin
      p = 16'(b_c[k]) * 16'(level);
      ps = 17'(p) + 17'(p[15:8]) + 17'd1;
      case (k)
        0: red_out <= light_on ? ps[15:8] : 8'd0;
        1: green_out <= light_on ? ps[15:8] : 8'd0;
        default: blue_out <= light_on ? ps[15:8] : 8'd0;
      endcase
    end
  end

endmodule

// ----- rtl/core/cxy_checker.sv -----
// Port-level checks for the converter and their binding to the top level.
module cxy_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       result_valid,
  input logic       cfg_ready
);
  import cxy_pkg::*;

  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");

  // Every accepted word yields a result after the fixed pipeline latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY result_valid)
    else $error("result missing after pipeline latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start, LATENCY))
    else $error("result without an accepted word");

endmodule

bind cie_xy_to_rgb_with_dimming cxy_checker u_cxy_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .result_valid(result_valid),
  .cfg_ready(cfg_ready)
);

// ----- bench/cie_xy_to_rgb_with_dimming_chk.sv -----
// Checker that predicts and compares the converter's RGB results.
`timescale 1ns / 100ps

module cie_xy_to_rgb_with_dimming_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] chroma_x,
  input  logic [15:0] chroma_y,
  input  logic        result_valid,
  input  logic [7:0]  red_out,
  input  logic [7:0]  green_out,
  input  logic [7:0]  blue_out,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          errors,
  output int          pending
);
  import cxy_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  rgb_t rgb_due[$];
  logic [7:0] level;
  logic       lamp_on;

  assign pending = rgb_due.size();

  function automatic u64_t root_floor(u64_t v);
    u64_t res;
    u64_t bitv;
    res = 0;
    bitv = 64'd1 << 32;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic rgb_t predict_rgb(logic [15:0] cx_in, logic [15:0] cy_in);
    longint sx, sy, su, mx;
    longint n [3];
    u64_t q, s, c;
    logic [7:0] chan [3];
    rgb_t o;
    sx = longint'(cx_in);
    sy = (cy_in < Y_MIN) ? longint'(Y_MIN) : longint'(cy_in);
    su = 65536 - sx - sy;
    n[0] = 32406 * sx - 15372 * sy - 4986 * su;
    n[1] = -9689 * sx + 18758 * sy + 415 * su;
    n[2] = 557 * sx - 2040 * sy + 10570 * su;
    mx = 0;
    for (int k = 0; k < 3; k++) begin
      if (n[k] < 0) n[k] = 0;
      if (n[k] > mx) mx = n[k];
    end
    for (int k = 0; k < 3; k++) begin
      c = 0;
      // A maximum no larger than y means the brightest channel is negligible.
      if (mx > sy) begin
        q = (u64_t'(n[k]) << 32) / u64_t'(mx);
        s = root_floor(q);
        c = (s * 255) >> 16;
      end
      chan[k] = lamp_on ? 8'((c * level) / 255) : 8'd0;
    end
    o.r = chan[0];
    o.g = chan[1];
    o.b = chan[2];
    return o;
  endfunction

  always @(posedge clk) begin
    rgb_t want;
    if (rst) begin
      level <= 8'd128;
      lamp_on <= 1'b0;
      rgb_due.delete();
      errors <= 0;
    end else begin
      if (result_valid) begin
        if (rgb_due.size() == 0) begin
          $display("%0t: result with none due: got %h %h %h", $time,
                   red_out, green_out, blue_out);
          errors <= errors + 1;
        end else begin
          want = rgb_due.pop_front();
          if (want != {red_out, green_out, blue_out}) begin
            $display("%0t: rgb mismatch: expected %h %h %h, actual %h %h %h", $time,
                     want.r, want.g, want.b, red_out, green_out, blue_out);
            errors <= errors + 1;
          end
        end
      end
      if (start && !busy) rgb_due.push_back(predict_rgb(chroma_x, chroma_y));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_LEVEL) level <= cfg_data;
        else if (cfg_index == REG_ON) lamp_on <= cfg_data[0];
      end
    end
  end

endmodule

// ----- bench/cie_xy_to_rgb_with_dimming_tb.sv -----
// Top of the converter testbench: stimulus, configuration and verdict.
`timescale 1ns / 100ps

module cie_xy_to_rgb_with_dimming_tb;
  import cxy_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [15:0] chroma_x = '0;
  logic [15:0] chroma_y = '0;
  logic result_valid;
  logic [7:0] red_out, green_out, blue_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  int errors, pending;
  int quiet_cycles = 0;
  bit idle_on = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  cie_xy_to_rgb_with_dimming DUT (.*);

  cie_xy_to_rgb_with_dimming_chk checker_i (.*);

  // Ends the run when nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(logic [15:0] xv, logic [15:0] yv);
    if (idle_on && $urandom_range(99) < 26) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    start <= 1'b1;
    chroma_x <= xv;
    chroma_y <= yv;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_word();
    logic [15:0] xv, yv;
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      // Physically meaningful points with x + y within one.
      xv = 16'($urandom_range(65535));
      yv = 16'($urandom_range(65535 - xv));
    end else if (pick < 70) begin
      xv = 16'($urandom);
      yv = 16'($urandom_range(10));
    end else if (pick < 80) begin
      xv = $urandom_range(1) ? 16'(16'hFFFF - $urandom_range(15))
                             : 16'($urandom_range(15));
      yv = 16'($urandom);
    end else begin
      xv = 16'($urandom);
      yv = 16'($urandom);
    end
    send_word(xv, yv);
  endtask

  initial begin
    logic [7:0] lv;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The light is off after reset, so the first words must all read zero.
    send_word(16'd20562, 16'd21627);
    send_word(16'hFFFF, 16'hFFFF);
    drain();
    write_reg(REG_LEVEL, 8'd255);
    write_reg(REG_ON, 8'd1);
    write_reg(2'd2, 8'hFF);
    write_reg(2'd3, 8'h00);

    send_word(16'd0, 16'd0);
    send_word(16'hFFFF, 16'hFFFF);
    send_word(16'd0, 16'hFFFF);
    send_word(16'hFFFF, 16'd0);
    send_word(16'd20562, 16'd21627);
    send_word(16'd41943, 16'd21627);
    send_word(16'd19661, 16'd39322);
    send_word(16'd9830, 16'd3932);
    send_word(16'd30000, 16'd6);
    send_word(16'd30000, 16'd7);
    send_word(16'd30000, 16'd8);
    send_word(16'd50000, 16'd40000);
    send_word(16'd0, 16'd1);
    send_word(16'd65535, 16'd1);
    send_word(16'h5555, 16'hAAAA);
    send_word(16'hAAAA, 16'h5555);
    // A pause so the sender waits until every word has come back.
    drain();
    send_word(16'd21627, 16'd20562);
    send_word(16'd1, 16'd65534);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: lv = 8'd0;
        1: lv = 8'd1;
        2: lv = 8'd128;
        3: lv = 8'd255;
        default: lv = 8'($urandom);
      endcase
      write_reg(REG_LEVEL, lv);
      write_reg(REG_ON, (ph == 4) ? 8'd0 : 8'hFF);
      idle_on = (ph != 3);
      for (int i = 0; i < 125; i++) random_word();
    end
    idle_on = 1'b1;

    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
